FILE: design/bclp_pkg.sv
package bclp_pkg;

  localparam int unsigned MS_W    = 10;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned TIMER_W = 17;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;

  localparam logic             ACTIVE_LEVEL_RST   = 1'b0;
  localparam logic [WIN_W-1:0] RELEASE_WINDOW_RST = 16'd300;
  localparam logic [WIN_W-1:0] PRESS_WINDOW_RST   = 16'd200;
  localparam logic [WIN_W-1:0] LONG_REPEAT_RST    = 16'd200;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_CLICK = 2'd1,
    KIND_LONG  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_LEVEL   = 2'd0,
    REG_RELEASE_WINDOW = 2'd1,
    REG_PRESS_WINDOW   = 2'd2,
    REG_LONG_REPEAT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             active_level;
    logic [WIN_W-1:0] release_window;
    logic [WIN_W-1:0] press_window;
    logic [WIN_W-1:0] long_repeat;
  } cfg_t;

  typedef struct packed {
    opcode_t         opcode;
    logic            pin_level;
    logic [MS_W-1:0] tick_ms;
  } item_t;

  typedef struct packed {
    logic               event_pending;
    logic               got_event;
    logic [KIND_W-1:0]  press_kind;
    logic [COUNT_W-1:0] press_count;
  } result_t;

endpackage

FILE: design/bclp_regs.sv
module bclp_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bclp_pkg::APB_AW-1:0] paddr,
  input  logic [bclp_pkg::APB_DW-1:0] pwdata,
  output logic [bclp_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output bclp_pkg::cfg_t              cfg
);
  import bclp_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ACTIVE_LEVEL:   cfg_nxt.active_level   = pwdata[0];
        REG_RELEASE_WINDOW: cfg_nxt.release_window = pwdata[WIN_W-1:0];
        REG_PRESS_WINDOW:   cfg_nxt.press_window   = pwdata[WIN_W-1:0];
        REG_LONG_REPEAT:    cfg_nxt.long_repeat    = pwdata[WIN_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACTIVE_LEVEL:   prdata = {{(APB_DW-1){1'b0}}, cfg_r.active_level};
      REG_RELEASE_WINDOW: prdata = {{(APB_DW-WIN_W){1'b0}}, cfg_r.release_window};
      REG_PRESS_WINDOW:   prdata = {{(APB_DW-WIN_W){1'b0}}, cfg_r.press_window};
      REG_LONG_REPEAT:    prdata = {{(APB_DW-WIN_W){1'b0}}, cfg_r.long_repeat};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level   <= ACTIVE_LEVEL_RST;
      cfg_r.release_window <= RELEASE_WINDOW_RST;
      cfg_r.press_window   <= PRESS_WINDOW_RST;
      cfg_r.long_repeat    <= LONG_REPEAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: design/bclp_engine.sv
module bclp_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  bclp_pkg::cfg_t    cfg,
  input  logic              fire,
  input  bclp_pkg::item_t   item,
  output bclp_pkg::result_t result
);
  import bclp_pkg::*;

  logic [TIMER_W-1:0] window_r, window_nxt;
  logic               armed_r, armed_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [TIMER_W-1:0] long_r, long_nxt;
  kind_t              kind_r, kind_nxt;
  logic               event_r, event_nxt;

  logic [TIMER_W-1:0] ms_ext;
  logic [TIMER_W-1:0] win_dec;
  logic [TIMER_W-1:0] win_press;
  logic [TIMER_W:0]   long_sum;
  logic [TIMER_W-1:0] rel_win_ext;

  assign ms_ext      = {{(TIMER_W-MS_W){1'b0}}, item.tick_ms};
  assign rel_win_ext = {{(TIMER_W-WIN_W){1'b0}}, cfg.release_window};

  always_comb begin
    window_nxt = window_r;
    armed_nxt  = armed_r;
    count_nxt  = count_r;
    long_nxt   = long_r;
    kind_nxt   = kind_r;
    event_nxt  = event_r;
    win_dec    = (window_r > ms_ext) ? (window_r - ms_ext) : '0;
    win_press  = win_dec;
    long_sum   = {1'b0, long_r} + {1'b0, ms_ext};

    result.got_event   = 1'b0;
    result.press_kind  = KIND_NONE;
    result.press_count = '0;

    case (item.opcode)
      OP_TICK: begin
        // While an event waits to be read, ticks leave the state alone.
        if (!event_r) begin
          if (item.pin_level == cfg.active_level) begin
            if (win_dec != '0) begin
              if (!armed_r) begin
                win_press = {{(TIMER_W-WIN_W){1'b0}}, cfg.press_window};
                count_nxt = count_r + 1'b1;
                armed_nxt = 1'b1;
              end
              kind_nxt = KIND_CLICK;
            end
            window_nxt = win_press;
            // A zero press window falls straight through to the long press path.
            if (win_press == '0) begin
              long_nxt = long_sum[TIMER_W-1:0];
              if (long_sum[TIMER_W-1:0] > {{(TIMER_W-WIN_W){1'b0}}, cfg.long_repeat}) begin
                long_nxt  = '0;
                event_nxt = 1'b1;
              end
              kind_nxt = KIND_LONG;
            end
          end else begin
            armed_nxt = 1'b0;
            long_nxt  = '0;
            if (window_r < rel_win_ext) begin
              window_nxt = window_r + ms_ext;
            end
            if (kind_r == KIND_CLICK && window_nxt >= rel_win_ext) begin
              event_nxt = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        if (event_r) begin
          result.got_event   = 1'b1;
          result.press_kind  = kind_r;
          result.press_count = count_r;
          count_nxt          = '0;
          event_nxt          = 1'b0;
        end
      end
      default: begin
        event_nxt = event_r;
      end
    endcase

    result.event_pending = event_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= {{(TIMER_W-WIN_W){1'b0}}, RELEASE_WINDOW_RST};
      armed_r  <= 1'b0;
      count_r  <= '0;
      long_r   <= '0;
      kind_r   <= KIND_NONE;
      event_r  <= 1'b0;
    end else if (fire) begin
      window_r <= window_nxt;
      armed_r  <= armed_nxt;
      count_r  <= count_nxt;
      long_r   <= long_nxt;
      kind_r   <= kind_nxt;
      event_r  <= event_nxt;
    end
  end

endmodule

FILE: design/bclp_outq.sv
module bclp_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bclp_pkg::result_t push_data,
  output logic              space,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output bclp_pkg::result_t out_data
);
  import bclp_pkg::*;

  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    head_v_r, head_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  logic    pop;

  assign pop       = head_v_r && !out_stall;
  assign full      = head_v_r && skid_v_r;
  assign space     = !full || pop;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

  always_comb begin
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        skid_nxt   = push_data;
        skid_v_nxt = push;
      end else begin
        head_nxt   = push_data;
        head_v_nxt = push;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_nxt   = push_data;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

endmodule

FILE: design/button_click_long_press_classifier.sv
// Channel   Ports                                           Direction
// input     in_valid, in_stall, in_opcode, in_pin_level,    item in
//           in_tick_ms
// result    out_valid, out_stall, out_event_pending,        one result per item
//           out_got_event, out_press_kind, out_press_count
// config    psel, penable, pwrite, paddr, pwdata, prdata,   register access
//           pready
//
// Each item is registered at the input, classified once the result buffer has
// space, and written into that two-entry buffer. One item per cycle is sustained
// while out_stall is low; the button state changes as each item is classified.
// in_stall rises only when the input register and both buffer entries are full.
// rst_n is synchronous; it restores the register defaults and the button state.
module button_click_long_press_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic                             in_pin_level,
  input  logic [bclp_pkg::MS_W-1:0]        in_tick_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_event_pending,
  output logic                             out_got_event,
  output logic [bclp_pkg::KIND_W-1:0]      out_press_kind,
  output logic [bclp_pkg::COUNT_W-1:0]     out_press_count,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bclp_pkg::APB_AW-1:0]      paddr,
  input  logic [bclp_pkg::APB_DW-1:0]      pwdata,
  output logic [bclp_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import bclp_pkg::*;

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    item_v_r, item_v_nxt;
  logic    in_fire;
  logic    fire;
  logic    q_space;
  logic    q_full;
  result_t result;
  result_t out_data;

  assign in_stall = item_v_r && q_full;
  assign in_fire  = in_valid && !in_stall;
  assign fire     = item_v_r && q_space;

  always_comb begin
    item_nxt   = item_r;
    item_v_nxt = item_v_r && !fire;
    if (in_fire) begin
      item_nxt.opcode    = opcode_t'(in_opcode);
      item_nxt.pin_level = in_pin_level;
      item_nxt.tick_ms   = in_tick_ms;
      item_v_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  bclp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bclp_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (fire),
    .item   (item_r),
    .result (result)
  );

  bclp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_data (result),
    .space     (q_space),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_event_pending = out_data.event_pending;
  assign out_got_event     = out_data.got_event;
  assign out_press_kind    = out_data.press_kind;
  assign out_press_count   = out_data.press_count;

endmodule
